// ===== rtl/core/sira_pkg.sv =====
// Shared types, widths and the digit alphabet for the signed integer to radix ASCII unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package sira_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAG_W     = VALUE_W + 1;
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 6;
  localparam int BUF_DEPTH = VALUE_W;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CYC   = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W     = DIV_CYC * DIV_STEPS;
  localparam int DCYC_W    = $clog2(DIV_CYC);
  localparam int S_DATA_W  = ((VALUE_W + RADIX_W + 7) / 8) * 8;
  localparam int M_DATA_W  = ((CHAR_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef struct packed {
    logic               err;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [RADIX_W-1:0] radix;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_W'(36)) begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end else begin
      c = CHAR_NONE;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sira_front.sv =====
// Front end: accepts input beats, checks the radix, takes the sign and the magnitude.
// Depends on sira_pkg; feeds sira_queue.
`default_nettype none
module sira_front (
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [sira_pkg::S_DATA_W-1:0] s_tdata_i,  // value[31:0], radix[37:32], zero pad
  input  wire logic                          full_i,
  output logic                               push_o,
  output sira_pkg::job_t                     job_o
);
  import sira_pkg::*;

  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;
  logic [MAG_W-1:0]   sext;

  assign value = s_tdata_i[VALUE_W-1:0];
  assign radix = s_tdata_i[VALUE_W +: RADIX_W];
  assign sext  = {value[VALUE_W-1], value};

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    job_o.err   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    job_o.neg   = value[VALUE_W-1];
    job_o.mag   = value[VALUE_W-1] ? (~sext + MAG_W'(1)) : sext;
    job_o.radix = radix;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sira_queue.sv =====
// Two-entry queue of classified jobs between the front end and the converter.
// Depends on sira_pkg.
`default_nettype none
module sira_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire sira_pkg::job_t job_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output sira_pkg::job_t job_o
);
  import sira_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== rtl/core/sira_back.sv =====
// Back end: divides the magnitude by the radix eight quotient bits a cycle, buffers the
// remainders and sends the characters most significant first. Depends on sira_pkg.
`default_nettype none
module sira_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire sira_pkg::job_t                q_job_i,
  output logic                               q_pop_o,
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  output logic [sira_pkg::M_DATA_W-1:0]      m_tdata_o,  // ascii_char[6:0], zero pad
  output logic                               m_tlast_o,
  output logic                               m_tuser_o   // error
);
  import sira_pkg::*;

  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DCYC_W-1:0]    dcyc_q, dcyc_d;
  logic [DIGIT_W-1:0]   part_q, part_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIGIT_W-1:0]   buf_q [BUF_DEPTH];
  logic                 buf_we;
  logic                 o_valid_q, o_valid_d;
  logic [CHAR_W-1:0]    o_char_q, o_char_d;
  logic                 o_last_q, o_last_d;
  logic                 o_err_q, o_err_d;
  logic                 out_free;
  logic                 div_done;
  logic                 div_stop;
  logic [DIV_W-1:0]     step_dvd;
  logic [DIGIT_W-1:0]   step_part;
  logic [DIGIT_W-1:0]   rd_digit;

  assign out_free = !o_valid_q || m_tready_i;
  assign rd_digit = buf_q[cnt_q[PTR_W-1:0] - PTR_W'(1)];

  // Eight restoring division steps per cycle
  always_comb begin
    logic [DIGIT_W:0] trial;
    step_dvd  = dvd_q;
    step_part = part_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {step_part, step_dvd[DIV_W-1]};
      step_dvd = {step_dvd[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial       = trial - {1'b0, radix_q};
        step_dvd[0] = 1'b1;
      end
      step_part = trial[DIGIT_W-1:0];
    end
  end

  assign div_done = (state_q == ST_DIV) && (dcyc_q == DCYC_W'(DIV_CYC - 1));
  assign div_stop = (step_dvd == '0) || (cnt_q == CNT_W'(BUF_DEPTH - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_job_i.err ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && div_stop) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    neg_d     = neg_q;
    radix_d   = radix_q;
    dvd_d     = dvd_q;
    dcyc_d    = dcyc_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    buf_we    = 1'b0;
    o_valid_d = o_valid_q && !m_tready_i;
    o_char_d  = o_char_q;
    o_last_d  = o_last_q;
    o_err_d   = o_err_q;
    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        neg_d   = q_job_i.neg;
        radix_d = q_job_i.radix;
        dvd_d   = DIV_W'(q_job_i.mag);
        dcyc_d  = '0;
        part_d  = '0;
        cnt_d   = '0;
      end
      ST_DIV: begin
        dvd_d  = step_dvd;
        part_d = step_part;
        dcyc_d = dcyc_q + DCYC_W'(1);
        if (div_done) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          dcyc_d = '0;
          part_d = '0;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_char_d  = CHAR_MINUS;
          o_last_d  = 1'b0;
          o_err_d   = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_char_d  = digit_char(rd_digit);
          o_last_d  = (cnt_q == CNT_W'(1));
          o_err_d   = 1'b0;
          cnt_d     = cnt_q - CNT_W'(1);
        end
      end
      ST_ERR: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_char_d  = CHAR_NONE;
          o_last_d  = 1'b1;
          o_err_d   = 1'b1;
        end
      end
      default: begin
        o_valid_d = o_valid_q && !m_tready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      dcyc_q    <= '0;
      neg_q     <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dcyc_q    <= dcyc_d;
      neg_q     <= neg_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q  <= radix_d;
    dvd_q    <= dvd_d;
    part_q   <= part_d;
    o_char_q <= o_char_d;
    o_last_q <= o_last_d;
    o_err_q  <= o_err_d;
    if (buf_we) begin
      buf_q[cnt_q[PTR_W-1:0]] <= step_part;
    end
  end

  assign m_tvalid_o = o_valid_q;
  assign m_tdata_o  = M_DATA_W'(o_char_q);
  assign m_tlast_o  = o_last_q;
  assign m_tuser_o  = o_err_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(BUF_DEPTH)) else $error("digit count beyond buffer");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SIGN) |-> cnt_q != '0) else $error("emit with no digits");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_err_q) |-> (o_last_q && o_char_q == CHAR_NONE)) else $error("bad error beat");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> part_q < radix_q) else $error("partial remainder not reduced");

endmodule
`default_nettype wire

// ===== rtl/core/signed_integer_to_radix_ascii_unit.sv =====
// A beat is written into the queue and picked up by the back end once it is idle; every
// digit is then worked out by the divider (8 quotient bits a cycle over a 40-bit dividend)
// before the first character leaves the output register. The back end converts one value
// at a time while the two-entry queue takes further beats; a bad radix gives one error beat.
// rst_ni clears the queue, the control and the output valid asynchronously.
// Top level: sira_front, sira_queue and sira_back; depends on sira_pkg.
`default_nettype none
module signed_integer_to_radix_ascii_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [sira_pkg::S_DATA_W-1:0] s_tdata_i,  // value[31:0], radix[37:32], zero pad
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  output logic [sira_pkg::M_DATA_W-1:0]      m_tdata_o,  // ascii_char[6:0], zero pad
  output logic                               m_tlast_o,
  output logic                               m_tuser_o   // error
);
  import sira_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic push;
  logic full;
  logic q_valid;
  logic q_pop;

  sira_front u_front (
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  sira_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (queue_job)
  );

  sira_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (queue_job),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule
`default_nettype wire
